// ===== sv/indexed_min_heap_queue_macros.svh =====
// assertion macros for the indexed min-heap queue
// used by the top level only, no other dependencies
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
`define IMHQ_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("imhq check failed");
`define IMHQ_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("imhq check failed");
`else
`define IMHQ_NEVER(label, clk, rst_n, cond)
`define IMHQ_IMPLY(label, clk, rst_n, a, b)
`endif
`endif

// ===== sv/imhq_pkg.sv =====
// shared constants and codes for the indexed min-heap queue
// no dependencies
package imhq_pkg;
    localparam int CAPACITY_DEF = 256;
    localparam int ID_SPACE_DEF = 1024;
    localparam int KEY_BITS_DEF = 32;

    localparam int OP_W    = 2;
    localparam int ID_W    = 10;
    localparam int FIELD_W = 32;
    localparam int ST_W    = 3;
    localparam int LIM_W   = 9;
    localparam logic [LIM_W-1:0] LIMIT_RESET = 9'd256;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SETKEY = 2'd1;
    localparam logic [OP_W-1:0] OP_DELMIN = 2'd2;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK      = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
    localparam logic [ST_W-1:0] ST_DUP     = 3'd2;
    localparam logic [ST_W-1:0] ST_MISSING = 3'd3;
    localparam logic [ST_W-1:0] ST_EMPTY   = 3'd4;
endpackage

// ===== sv/imhq_if.sv =====
// request and response channel interfaces of the indexed min-heap queue
// depends on imhq_pkg
interface imhq_req_if;
    logic                              valid;
    logic                              ready;
    logic [imhq_pkg::OP_W-1:0]         operation;
    logic [imhq_pkg::ID_W-1:0]         entry_id;
    logic signed [imhq_pkg::FIELD_W-1:0] entry_key;
    logic [imhq_pkg::FIELD_W-1:0]      entry_payload;
    modport source (output valid, operation, entry_id, entry_key, entry_payload, input ready);
    modport sink (input valid, operation, entry_id, entry_key, entry_payload, output ready);
endinterface

interface imhq_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [imhq_pkg::ST_W-1:0]         status;
    logic [imhq_pkg::ID_W-1:0]         taken_id;
    logic signed [imhq_pkg::FIELD_W-1:0] taken_key;
    logic [imhq_pkg::FIELD_W-1:0]      taken_payload;
    modport source (output valid, status, taken_id, taken_key, taken_payload, input ready);
    modport sink (input valid, status, taken_id, taken_key, taken_payload, output ready);
endinterface

// ===== sv/indexed_min_heap_queue.sv =====
// indexed min-heap queue: one request word in, one response word out; each sift
// level waits on a heap ram read; one word in flight at a time
// after reset the handle table is cleared one entry a cycle while no request
// is taken; configuration writes are taken at any time
// depends on imhq_pkg, imhq_if, imhq_ram and indexed_min_heap_queue_macros.svh
`include "indexed_min_heap_queue_macros.svh"
module indexed_min_heap_queue #(
    parameter int CAPACITY = imhq_pkg::CAPACITY_DEF,
    parameter int ID_SPACE = imhq_pkg::ID_SPACE_DEF,
    parameter int KEY_BITS = imhq_pkg::KEY_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    imhq_req_if.sink                   req,
    imhq_rsp_if.source                 rsp,
    input  logic                       wr_en,
    input  logic [imhq_pkg::LIM_W-1:0] wr_data
);
    localparam int KW = KEY_BITS;
    localparam int IDW = imhq_pkg::ID_W;
    localparam int FW = imhq_pkg::FIELD_W;
    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int IW = $clog2(ID_SPACE);
    localparam int EW = KW + IDW + FW;

    typedef enum logic [11:0] {
        S_CLEAR = 12'b000000000001,
        S_IDLE  = 12'b000000000010,
        S_LOOK  = 12'b000000000100,
        S_FETCH = 12'b000000001000,
        S_TAKE1 = 12'b000000010000,
        S_TAKE2 = 12'b000000100000,
        S_UP    = 12'b000001000000,
        S_UPCMP = 12'b000010000000,
        S_DN    = 12'b000100000000,
        S_DN1   = 12'b001000000000,
        S_DN2   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic signed [KW-1:0] key;
        logic [IDW-1:0]       id;
        logic [FW-1:0]        pay;
    } entry_t;

    function automatic logic [KW-1:0] key_in(input logic [FW-1:0] f);
        logic [KW-1:0] k;
        for (int i = 0; i < KW; i++)
        begin
            k[i] = (i < FW) ? f[i % FW] : 1'b0;
        end
        return k;
    endfunction

    function automatic logic [FW-1:0] key_out(input logic [KW-1:0] k);
        logic [FW-1:0] f;
        for (int i = 0; i < FW; i++)
        begin
            f[i] = (i < KW) ? k[i % KW] : k[KW-1];
        end
        return f;
    endfunction

    state_t state_reg, state_next;
    logic [PW-1:0] cnt_reg, cnt_next;
    logic [imhq_pkg::LIM_W-1:0] limit_reg;
    logic [IW-1:0] clr_reg, clr_next;
    logic [imhq_pkg::OP_W-1:0] op_reg, op_next;
    logic [IDW-1:0] id_reg, id_next;
    logic id_ok_reg, id_ok_next;
    logic [KW-1:0] key_reg, key_next;
    logic [FW-1:0] pay_reg, pay_next;
    logic [PW-1:0] slot_reg, slot_next;
    logic [PW-1:0] hole_reg, hole_next;
    entry_t mov_reg, mov_next, cand_reg, cand_next;
    logic [PW-1:0] cidx_reg, cidx_next;
    logic [imhq_pkg::ST_W-1:0] rst_reg, rst_next;
    logic [IDW-1:0] rid_reg, rid_next;
    logic [FW-1:0] rkey_reg, rkey_next, rpay_reg, rpay_next;
    logic ov_reg, ov_next;
    logic [imhq_pkg::ST_W-1:0] ost_reg, ost_next;
    logic [IDW-1:0] oid_reg, oid_next;
    logic [FW-1:0] okey_reg, okey_next, opay_reg, opay_next;

    logic heap_we;
    logic [AW-1:0] heap_waddr, heap_raddr;
    entry_t heap_wdata, heap_rdata;
    logic pos_we;
    logic [IW-1:0] pos_waddr, pos_raddr;
    logic [PW-1:0] pos_wdata, pos_rdata;

    imhq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_heap (
        .clk(clk), .we(heap_we), .waddr(heap_waddr), .wdata(heap_wdata),
        .raddr(heap_raddr), .rdata(heap_rdata)
    );

    imhq_ram #(.WIDTH(PW), .DEPTH(ID_SPACE)) u_pos (
        .clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
        .raddr(pos_raddr), .rdata(pos_rdata)
    );

    logic [PW-1:0] pos_v;
    logic full;
    logic [PW:0] c_wide;
    entry_t best;
    logic [PW-1:0] best_idx;
    logic have_best;

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.status = ost_reg;
    assign rsp.taken_id = oid_reg;
    assign rsp.taken_key = okey_reg;
    assign rsp.taken_payload = opay_reg;

    assign pos_v = id_ok_reg ? pos_rdata : '0;
    assign full = (32'(cnt_reg) >= 32'(limit_reg)) || (32'(cnt_reg) >= CAPACITY);
    assign c_wide = {hole_reg, 1'b0};

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        clr_next = clr_reg;
        op_next = op_reg;
        id_next = id_reg;
        id_ok_next = id_ok_reg;
        key_next = key_reg;
        pay_next = pay_reg;
        slot_next = slot_reg;
        hole_next = hole_reg;
        mov_next = mov_reg;
        cand_next = cand_reg;
        cidx_next = cidx_reg;
        rst_next = rst_reg;
        rid_next = rid_reg;
        rkey_next = rkey_reg;
        rpay_next = rpay_reg;
        ov_next = ov_reg && !rsp.ready;
        ost_next = ost_reg;
        oid_next = oid_reg;
        okey_next = okey_reg;
        opay_next = opay_reg;
        heap_we = 1'b0;
        heap_waddr = AW'(hole_reg - PW'(1));
        heap_wdata = mov_reg;
        heap_raddr = '0;
        pos_we = 1'b0;
        pos_waddr = IW'(mov_reg.id);
        pos_wdata = hole_reg;
        pos_raddr = IW'(req.entry_id);
        best = heap_rdata;
        best_idx = PW'(c_wide);
        have_best = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                pos_we = 1'b1;
                pos_waddr = clr_reg;
                pos_wdata = '0;
                clr_next = clr_reg + IW'(1);
                if (32'(clr_reg) == ID_SPACE - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next = req.operation;
                    id_next = req.entry_id;
                    id_ok_next = (32'(req.entry_id) < ID_SPACE);
                    key_next = key_in(req.entry_key);
                    pay_next = req.entry_payload;
                    rst_next = imhq_pkg::ST_OK;
                    rid_next = '0;
                    rkey_next = '0;
                    rpay_next = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                case (op_reg)
                    imhq_pkg::OP_INSERT:
                    begin
                        if (full)
                        begin
                            rst_next = imhq_pkg::ST_FULL;
                            state_next = S_OUT;
                        end
                        else if (!id_ok_reg)
                        begin
                            rst_next = imhq_pkg::ST_MISSING;
                            state_next = S_OUT;
                        end
                        else if (pos_v != '0)
                        begin
                            rst_next = imhq_pkg::ST_DUP;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            mov_next = '{key: key_reg, id: id_reg, pay: pay_reg};
                            hole_next = cnt_reg + PW'(1);
                            cnt_next = cnt_reg + PW'(1);
                            state_next = S_UP;
                        end
                    end
                    imhq_pkg::OP_DELMIN:
                    begin
                        if (cnt_reg == '0)
                        begin
                            rst_next = imhq_pkg::ST_EMPTY;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            heap_raddr = '0;
                            slot_next = PW'(1);
                            state_next = S_TAKE1;
                        end
                    end
                    default:
                    begin
                        if (pos_v == '0 || pos_v > cnt_reg)
                        begin
                            rst_next = imhq_pkg::ST_MISSING;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            heap_raddr = AW'(pos_v - PW'(1));
                            slot_next = pos_v;
                            state_next = (op_reg == imhq_pkg::OP_SETKEY) ? S_FETCH : S_TAKE1;
                        end
                    end
                endcase
            end
            S_FETCH:
            begin
                mov_next = '{key: key_reg, id: heap_rdata.id, pay: heap_rdata.pay};
                hole_next = slot_reg;
                state_next = S_UP;
            end
            S_TAKE1:
            begin
                rid_next = (op_reg == imhq_pkg::OP_DELMIN) ? heap_rdata.id : '0;
                rkey_next = key_out(heap_rdata.key);
                rpay_next = heap_rdata.pay;
                pos_we = 1'b1;
                pos_waddr = IW'(heap_rdata.id);
                pos_wdata = '0;
                heap_raddr = AW'(cnt_reg - PW'(1));
                state_next = S_TAKE2;
            end
            S_TAKE2:
            begin
                cnt_next = cnt_reg - PW'(1);
                if (slot_reg == cnt_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    mov_next = heap_rdata;
                    hole_next = slot_reg;
                    state_next = S_UP;
                end
            end
            S_UP:
            begin
                if (hole_reg == PW'(1))
                begin
                    state_next = S_DN;
                end
                else
                begin
                    heap_raddr = AW'((hole_reg >> 1) - PW'(1));
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (mov_reg.key < heap_rdata.key)
                begin
                    // parent drops into the hole
                    heap_we = 1'b1;
                    heap_wdata = heap_rdata;
                    pos_we = 1'b1;
                    pos_waddr = IW'(heap_rdata.id);
                    hole_next = hole_reg >> 1;
                    state_next = S_UP;
                end
                else
                begin
                    state_next = S_DN;
                end
            end
            S_DN:
            begin
                if (c_wide > (PW+1)'(cnt_reg))
                begin
                    heap_we = 1'b1;
                    pos_we = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    heap_raddr = AW'(c_wide - (PW+1)'(1));
                    state_next = S_DN1;
                end
            end
            S_DN1:
            begin
                cand_next = heap_rdata;
                cidx_next = PW'(c_wide);
                if (c_wide + (PW+1)'(1) <= (PW+1)'(cnt_reg))
                begin
                    heap_raddr = AW'(c_wide);
                    state_next = S_DN2;
                end
                else
                begin
                    have_best = 1'b1;
                end
            end
            S_DN2:
            begin
                have_best = 1'b1;
                if (heap_rdata.key < cand_reg.key)
                begin
                    best_idx = cidx_reg + PW'(1);
                end
                else
                begin
                    best = cand_reg;
                    best_idx = cidx_reg;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next = 1'b1;
                    ost_next = rst_reg;
                    oid_next = rid_reg;
                    okey_next = rkey_reg;
                    opay_next = rpay_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (have_best)
        begin
            heap_we = 1'b1;
            pos_we = 1'b1;
            if (best.key < mov_reg.key)
            begin
                // smaller child rises into the hole
                heap_wdata = best;
                pos_waddr = IW'(best.id);
                hole_next = best_idx;
                state_next = S_DN;
            end
            else
            begin
                state_next = S_OUT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg <= '0;
            clr_reg <= '0;
            limit_reg <= imhq_pkg::LIMIT_RESET;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            clr_reg <= clr_next;
            ov_reg <= ov_next;
            if (wr_en)
            begin
                limit_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        id_reg <= id_next;
        id_ok_reg <= id_ok_next;
        key_reg <= key_next;
        pay_reg <= pay_next;
        slot_reg <= slot_next;
        hole_reg <= hole_next;
        mov_reg <= mov_next;
        cand_reg <= cand_next;
        cidx_reg <= cidx_next;
        rst_reg <= rst_next;
        rid_reg <= rid_next;
        rkey_reg <= rkey_next;
        rpay_reg <= rpay_next;
        ost_reg <= ost_next;
        oid_reg <= oid_next;
        okey_reg <= okey_next;
        opay_reg <= opay_next;
    end

    `IMHQ_NEVER(a_cnt_bound, clk, rst_n, 32'(cnt_reg) > CAPACITY)
    `IMHQ_IMPLY(a_no_req_in_clear, clk, rst_n, state_reg == S_CLEAR, !req.ready)
    `IMHQ_IMPLY(a_empty_zero, clk, rst_n, ov_reg && ost_reg == imhq_pkg::ST_EMPTY,
        okey_reg == '0 && oid_reg == '0)
endmodule

// ===== sv/imhq_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module imhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
